// File: rtl/core/rbed_pkg.sv
// shared types and constants of the raw block exponent decompressor
`default_nettype none

package rbed_pkg;

    // field widths of the compressed stream
    localparam int unsigned EXP_BITS  = 3;
    localparam int unsigned MANT_BITS = 6;
    localparam int unsigned BYTE_W    = 8;

    // bit buffer holds at most 13 unconsumed bits plus headroom
    localparam int unsigned BUF_W = 15;
    localparam int unsigned CNT_W = 4;

    // pixel and octet geometry
    localparam int unsigned PIX_W     = 14;
    localparam int unsigned OCTET_N   = 8;
    localparam int unsigned SLOT_W    = 3;
    localparam int unsigned OCT_IDX_W = 2;
    localparam int unsigned POS_W     = 5;
    localparam int unsigned FIDX_W    = 3;

    // field index codes
    localparam logic [FIDX_W-1:0] FIDX_EXP      = 3'd0;
    localparam logic [FIDX_W-1:0] FIDX_MANT_FST = 3'd1;
    localparam logic [FIDX_W-1:0] FIDX_MANT_LST = 3'd4;

    // completed octet handed from the decoder to the emitter
    typedef struct packed {
        logic                                 valid;
        logic [OCT_IDX_W-1:0]                 octet;
        logic [OCTET_N-1:0][PIX_W-1:0]        pixels;
    } t_octet;

endpackage

`default_nettype wire

// File: rtl/core/raw_block_exponent_decompressor_core.sv
// top level of the raw block exponent decompressor
//
// channel  dir  payload                                      end marker
// s        in   tdata[7:0] code byte, lsb read first         -
// m        out  tdata[13:0] pixel value, [18:14] position    tlast on position 31
//
// up to one byte is taken per cycle; 27 bytes give 32 pixels in groups of eight
// pixels leave at one per cycle from an octet buffer while the sink is ready;
// the buffer accepts a new octet only after its last pixel has moved out
// the byte register holds while an octet completes and the buffer is still full
// reset is synchronous and active low and restarts at a block boundary
// a stalled output keeps its pixel; input stalls only through the octet buffer
`default_nettype none

module raw_block_exponent_decompressor_core
    import rbed_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [7:0] code_byte
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [23:0]      o_m_tdata,   // [13:0] pixel_value, [18:14] pixel_position
    output logic             o_m_tlast    // block_end
);

    t_octet           octet;
    logic             emit_busy;
    logic [PIX_W-1:0] pixel_value;
    logic [POS_W-1:0] pixel_position;

    // byte unpacking and octet assembly
    rbed_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_emit_busy (emit_busy),
        .o_octet     (octet)
    );

    // pixel serialization
    rbed_emit u_emit (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_octet          (octet),
        .o_busy           (emit_busy),
        .o_m_tvalid       (o_m_tvalid),
        .i_m_tready       (i_m_tready),
        .o_pixel_value    (pixel_value),
        .o_pixel_position (pixel_position),
        .o_block_end      (o_m_tlast)
    );

    assign o_m_tdata = {5'b0, pixel_position, pixel_value};

endmodule

`default_nettype wire

// File: rtl/core/rbed_decode.sv
// input register, bit unpacker and octet assembly
`default_nettype none

module rbed_decode
    import rbed_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_tvalid,
    output logic                   o_s_tready,
    input  wire logic [BYTE_W-1:0] i_s_tdata,
    input  wire logic              i_emit_busy,
    output t_octet                 o_octet
);

    // input register
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;

    // decoder state
    logic [BUF_W-1:0]              r_bit_buffer, n_bit_buffer;
    logic [CNT_W-1:0]              r_bit_count, n_bit_count;
    logic [EXP_BITS-1:0]           r_exp, n_exp;
    logic [FIDX_W-1:0]             r_fidx, n_fidx;
    logic                          r_odd, n_odd;
    logic [OCT_IDX_W-1:0]          r_octet_idx, n_octet_idx;
    logic [OCTET_N-1:0][PIX_W-1:0] r_pixels, n_pixels;
    logic                          n_done;
    logic                          dec_fire;

    // unpack up to two fields per byte; three never fit in 13 bits
    always_comb begin
        logic                 want_exp;
        logic [CNT_W-1:0]     need;
        logic [MANT_BITS-1:0] val;
        logic [SLOT_W-1:0]    slot;
        logic [FIDX_W-1:0]    fm1;
        logic [PIX_W-1:0]     wide_val;
        logic [CNT_W-1:0]     shamt;

        want_exp     = 1'b0;
        need         = '0;
        val          = '0;
        slot         = '0;
        fm1          = '0;
        wide_val     = '0;
        shamt        = '0;
        n_bit_buffer = BUF_W'(({{(BUF_W-BYTE_W){1'b0}}, r_in_byte} << r_bit_count)
                              | r_bit_buffer);
        n_bit_count  = r_bit_count + CNT_W'(BYTE_W);
        n_exp        = r_exp;
        n_fidx       = r_fidx;
        n_odd        = r_odd;
        n_octet_idx  = r_octet_idx;
        n_pixels     = r_pixels;
        n_done       = 1'b0;

        for (int k = 0; k < 2; k++) begin
            want_exp = (n_fidx == FIDX_EXP) || (n_fidx > FIDX_MANT_LST);
            need     = want_exp ? CNT_W'(EXP_BITS) : CNT_W'(MANT_BITS);
            if (n_bit_count >= need) begin
                val = want_exp ? {{(MANT_BITS-EXP_BITS){1'b0}}, n_bit_buffer[EXP_BITS-1:0]}
                               : n_bit_buffer[MANT_BITS-1:0];
                n_bit_buffer = n_bit_buffer >> need;
                n_bit_count  = n_bit_count - need;
                if (want_exp) begin
                    n_exp  = val[EXP_BITS-1:0];
                    n_fidx = FIDX_MANT_FST;
                end else begin
                    // first group on even slots, second on odd slots
                    fm1      = n_fidx - FIDX_MANT_FST;
                    slot     = {fm1[1:0], n_odd};
                    wide_val = {{(PIX_W-MANT_BITS){1'b0}}, val};
                    shamt    = {1'b0, n_exp} + 4'd1;
                    n_pixels[slot] = wide_val << shamt;
                    if (n_fidx < FIDX_MANT_LST) begin
                        n_fidx = n_fidx + 3'd1;
                    end else begin
                        n_fidx = FIDX_EXP;
                        if (!n_odd) begin
                            n_odd = 1'b1;
                        end else begin
                            n_odd       = 1'b0;
                            n_done      = 1'b1;
                            n_octet_idx = r_octet_idx + 2'd1;
                        end
                    end
                end
            end
        end
    end

    // hold the byte while a finished octet cannot be handed over
    assign dec_fire   = r_in_valid && !(n_done && i_emit_busy);
    assign o_s_tready = !r_in_valid || dec_fire;

    // octet handoff, taken by the emitter in the same cycle
    assign o_octet.valid  = dec_fire && n_done;
    assign o_octet.octet  = r_octet_idx;
    assign o_octet.pixels = n_pixels;

    // input register and decoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_bit_buffer <= '0;
            r_bit_count  <= '0;
            r_exp        <= '0;
            r_fidx       <= FIDX_EXP;
            r_odd        <= 1'b0;
            r_octet_idx  <= '0;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (dec_fire) begin
                r_bit_buffer <= n_bit_buffer;
                r_bit_count  <= n_bit_count;
                r_exp        <= n_exp;
                r_fidx       <= n_fidx;
                r_odd        <= n_odd;
                r_octet_idx  <= n_octet_idx;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
        end
        if (dec_fire) begin
            r_pixels <= n_pixels;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/rbed_emit.sv
// octet buffer and pixel output register
`default_nettype none

module rbed_emit
    import rbed_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire t_octet       i_octet,
    output logic              o_busy,
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    output logic [PIX_W-1:0]  o_pixel_value,
    output logic [POS_W-1:0]  o_pixel_position,
    output logic              o_block_end
);

    logic                          r_busy;
    logic [SLOT_W-1:0]             r_cnt;
    logic [OCT_IDX_W-1:0]          r_octet;
    logic [OCTET_N-1:0][PIX_W-1:0] r_pix;
    logic                          r_out_valid;
    logic [PIX_W-1:0]              r_out_value;
    logic [POS_W-1:0]              r_out_pos;
    logic                          r_out_last;
    logic                          move;
    logic [POS_W-1:0]              pos;

    assign pos  = {r_octet, r_cnt};
    assign move = r_busy && (!r_out_valid || i_m_tready);

    // control: buffer occupancy, pixel counter, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_octet.valid) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (move) begin
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt == SLOT_W'(OCTET_N - 1)) begin
                    r_busy <= 1'b0;
                end
            end
            if (move) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload: octet copy and output pixel
    always_ff @(posedge i_clk) begin
        if (i_octet.valid) begin
            r_pix   <= i_octet.pixels;
            r_octet <= i_octet.octet;
        end
        if (move) begin
            r_out_value <= r_pix[r_cnt];
            r_out_pos   <= pos;
            r_out_last  <= &pos;
        end
    end

    assign o_busy           = r_busy;
    assign o_m_tvalid       = r_out_valid;
    assign o_pixel_value    = r_out_value;
    assign o_pixel_position = r_out_pos;
    assign o_block_end      = r_out_last;

endmodule

`default_nettype wire

// File: tb/raw_block_exponent_decompressor_core_tb.sv
// self-checking testbench for the raw block exponent decompressor core
module raw_block_exponent_decompressor_core_tb;
    import rbed_pkg::*;

    localparam int CLK_HALF       = 10;
    localparam int RESET_CYCLES   = 2;
    localparam int MAX_IDLE       = 12;
    localparam int HOLD_CYCLES    = 150;
    localparam int DRAIN_CYCLES   = 24;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int MAX_REPORTS    = 10;
    localparam int BLOCK_BYTES    = 27;
    localparam int GROUPS_N       = 8;
    localparam int MANTS_N        = 4;
    localparam int EXP_BIAS       = 1;
    localparam int PHASE_ITEMS    = 90;
    localparam int HOLD_ITEMS     = 48;
    localparam logic [POS_W-1:0] LAST_POS = 5'd31;

    // one decoded pixel as it leaves the block
    typedef struct packed {
        logic [PIX_W-1:0] value;
        logic [POS_W-1:0] pos;
        logic             last;
    } t_pixel;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic [7:0]  i_s_tdata  = '0;   // [7:0] code_byte
    logic        i_m_tready = 1'b0;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [23:0] o_m_tdata;         // [13:0] pixel_value, [18:14] pixel_position
    logic        o_m_tlast;         // block_end

    // idling controls of the stimulus and the sink
    bit src_idle    = 1'b1;
    bit sink_idle   = 1'b1;
    bit hold_output = 1'b0;

    int error_count  = 0;
    int stall_cycles = 0;

    t_pixel expected_pixels[$];

    // decoder state mirrored on the bench side
    logic [BUF_W-1:0]     dec_bits  = '0;
    logic [CNT_W-1:0]     dec_count = '0;
    logic [EXP_BITS-1:0]  dec_exp   = '0;
    logic [FIDX_W-1:0]    dec_field = FIDX_EXP;
    logic                 dec_odd   = 1'b0;
    logic [OCT_IDX_W-1:0] dec_octet = '0;
    logic [PIX_W-1:0]     dec_pixels [OCTET_N];

    raw_block_exponent_decompressor_core u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    // clock
    always #CLK_HALF i_clk = ~i_clk;

    // abort when neither side moves for too long
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no request accepted for %0d cycles", stall_cycles);
            $display("raw_block_exponent_decompressor_core test failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic void note_error(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("mismatch: %s", msg);
    endfunction

    // unpack one byte lsb first, queue the octet once its last mantissa is read
    task automatic predict_byte(input logic [7:0] code);
        logic [31:0]   merged;
        logic          want_exp;
        int unsigned   width;
        logic [5:0]    field;
        logic [31:0]   scaled;
        int unsigned   slot;
        int            i;
        t_pixel        pix;
        merged    = {17'd0, dec_bits} | ({24'd0, code} << dec_count);
        dec_bits  = merged[BUF_W-1:0];
        dec_count = dec_count + CNT_W'(BYTE_W);
        while (1) begin
            // out-of-range field index falls back to the exponent
            want_exp = (dec_field == FIDX_EXP) || (dec_field > FIDX_MANT_LST);
            width    = want_exp ? EXP_BITS : MANT_BITS;
            if (dec_count < width)
                break;
            field     = 6'(dec_bits & BUF_W'((1 << width) - 1));
            dec_bits  = dec_bits >> width;
            dec_count = dec_count - CNT_W'(width);
            if (want_exp) begin
                dec_exp   = field[EXP_BITS-1:0];
                dec_field = FIDX_MANT_FST;
                continue;
            end
            // first group of a pair on even slots, second on odd
            slot = ((int'(dec_field) - int'(FIDX_MANT_FST)) * 2 + int'(dec_odd)) % OCTET_N;
            scaled = 32'(field) << (int'(dec_exp) + EXP_BIAS);
            dec_pixels[slot] = scaled[PIX_W-1:0];
            if (dec_field < FIDX_MANT_LST) begin
                dec_field = dec_field + 1'b1;
                continue;
            end
            dec_field = FIDX_EXP;
            if (!dec_odd) begin
                dec_odd = 1'b1;
                continue;
            end
            dec_odd = 1'b0;
            for (i = 0; i < OCTET_N; i++) begin
                pix.value = dec_pixels[i];
                pix.pos   = {dec_octet, SLOT_W'(i)};
                pix.last  = (pix.pos == LAST_POS);
                expected_pixels.push_back(pix);
            end
            dec_octet = dec_octet + 1'b1;
        end
    endtask

    // drive one code byte and wait for its request to be taken
    task automatic send_byte(input logic [7:0] code);
        int unsigned wait_cycles;
        wait_cycles = src_idle ? $urandom_range(MAX_IDLE, 0) : 0;
        if (wait_cycles > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (wait_cycles) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= code;
        do @(posedge i_clk); while (!(i_s_tvalid && o_s_tready));
        predict_byte(code);
    endtask

    task automatic release_input;
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_drained;
        int n;
        n = 0;
        while (expected_pixels.size() != 0 && n < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            n++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // compare one accepted pixel with the oldest expectation
    task automatic check_pixel(input t_pixel got);
        t_pixel want;
        if (expected_pixels.size() == 0) begin
            note_error($sformatf("unexpected pixel value %0d position %0d last %0b",
                                 got.value, got.pos, got.last));
            return;
        end
        want = expected_pixels.pop_front();
        if (got.value !== want.value)
            note_error($sformatf("position %0d value expected %0d got %0d",
                                 want.pos, want.value, got.value));
        if (got.pos !== want.pos)
            note_error($sformatf("position expected %0d got %0d", want.pos, got.pos));
        if (got.last !== want.last)
            note_error($sformatf("position %0d block end expected %0b got %0b",
                                 want.pos, want.last, got.last));
    endtask

    // output side: random ready gaps, one long hold on request
    initial begin : result_sink
        int unsigned wait_cycles;
        t_pixel      got;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            wait_cycles = sink_idle ? $urandom_range(MAX_IDLE, 0) : 0;
            if (hold_output) begin
                wait_cycles = HOLD_CYCLES;
                hold_output = 1'b0;
            end
            if (wait_cycles > 0) begin
                i_m_tready <= 1'b0;
                repeat (wait_cycles) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!(o_m_tvalid && i_m_tready));
            got.value = o_m_tdata[PIX_W-1:0];
            got.pos   = o_m_tdata[PIX_W +: POS_W];
            got.last  = o_m_tlast;
            check_pixel(got);
        end
    end

    // one aligned block: every exponent, mantissas at zero, full scale, walking and inverted walking bits
    task automatic test_exponent_sweep;
        logic [8*BLOCK_BYTES-1:0] block_bits;
        logic [MANT_BITS-1:0]     mant;
        int                       g, k, b, p;
        block_bits = '0;
        p = 0;
        for (g = 0; g < GROUPS_N; g++) begin
            block_bits[p +: EXP_BITS] = 3'(g);
            p += EXP_BITS;
            for (k = 0; k < MANTS_N; k++) begin
                case (k)
                    0: mant = '1;
                    1: mant = '0;
                    2: mant = 6'(1 << (g % MANT_BITS));
                    default: mant = ~6'(1 << (g % MANT_BITS));
                endcase
                block_bits[p +: MANT_BITS] = mant;
                p += MANT_BITS;
            end
        end
        for (b = 0; b < BLOCK_BYTES; b++)
            send_byte(block_bits[8*b +: 8]);
        release_input();
    endtask

    // sink stops for a long while, bytes keep coming until the input stalls
    task automatic test_output_hold;
        int n;
        wait_drained();
        src_idle    = 1'b0;
        sink_idle   = 1'b0;
        hold_output = 1'b1;
        for (n = 0; n < HOLD_ITEMS; n++)
            send_byte(8'($urandom_range(255, 0)));
        release_input();
    endtask

    // long stream in phases with different idling on each side
    task automatic test_random_stream;
        int          phase, n;
        int unsigned pick;
        logic [7:0]  code;
        for (phase = 0; phase < 4; phase++) begin
            src_idle  = (phase == 0) || (phase == 2);
            sink_idle = (phase == 0) || (phase == 3);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                // runs of all ones and all zeros reach full-scale and zero pixels
                pick = $urandom_range(99, 0);
                if (pick < 70)
                    code = 8'($urandom_range(255, 0));
                else if (pick < 85)
                    code = '1;
                else
                    code = '0;
                send_byte(code);
            end
        end
        release_input();
    endtask

    // test sequence
    initial begin : test_sequence
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_exponent_sweep();
        test_output_hold();
        test_random_stream();
        wait_drained();
        if (expected_pixels.size() != 0)
            note_error($sformatf("%0d expected pixels never arrived", expected_pixels.size()));
        if (error_count == 0) begin
            $display("raw_block_exponent_decompressor_core test passed");
        end else begin
            $display("raw_block_exponent_decompressor_core test failed");
        end
        $finish;
    end

endmodule
